>>> rtl/particulate_frame_parser_assert.svh
`ifndef PARTICULATE_FRAME_PARSER_ASSERT_SVH
`define PARTICULATE_FRAME_PARSER_ASSERT_SVH

// Same-cycle check: whenever the antecedent holds, the consequent holds too.
`define PFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: the consequent holds in the cycle after the antecedent.
`define PFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pfp_pkg.sv
package pfp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_CONTEXT       = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] HEADER_FIRST_RST  = 8'd66;
  localparam logic [7:0] HEADER_SECOND_RST = 8'd77;

  // Byte offsets of the 16-bit big-endian words inside a frame.
  localparam int STD_BASE   = 4;
  localparam int ATM_BASE   = 10;
  localparam int COUNT_BASE = 16;
  localparam int NUM_PM     = 3;
  localparam int NUM_COUNTS = 6;

  // Configuration seen by the result logic.
  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic       context_atm;
  } pfp_cfg_t;

  // Status of the byte currently in the input stage.
  typedef struct packed {
    logic        last;  // data byte that completes a frame
    logic [15:0] sum;   // running sum, including this byte if it is a summed byte
  } pfp_status_t;

  // One result item.
  typedef struct packed {
    logic        frame_ok;
    logic [15:0] pm1_0;
    logic [15:0] pm2_5;
    logic [15:0] pm10;
    logic [15:0] count_0_3;
    logic [15:0] count_0_5;
    logic [15:0] count_1_0;
    logic [15:0] count_2_5;
    logic [15:0] count_5_0;
    logic [15:0] count_10;
  } pfp_result_t;

endpackage

>>> rtl/pfp_assembler.sv
`include "particulate_frame_parser_assert.svh"

module pfp_assembler #(
  parameter int FRAME_BYTES  = 32,
  parameter int SUMMED_BYTES = 30
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                mode,
  input  logic [7:0]          rx_byte,
  output logic [7:0]          frame_byte [FRAME_BYTES],
  output pfp_pkg::pfp_status_t status
);
  import pfp_pkg::*;

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam int CMP_W = POS_W + 1;

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [15:0]      sum_r;
  logic [15:0]      sum_nxt;
  logic [15:0]      sum_add;
  logic             counted;
  logic             last;
  logic [7:0]       shift_r [FRAME_BYTES-1];

  // Position and sum decode for the byte in the input stage.
  assign last    = !mode && (pos_r == POS_W'(FRAME_BYTES - 1));
  assign counted = ({1'b0, pos_r} < CMP_W'(SUMMED_BYTES));
  assign sum_add = counted ? (sum_r + {8'd0, rx_byte}) : sum_r;

  assign status.last = last;
  assign status.sum  = sum_add;

  // Next position and sum: a timeout or a completed frame starts over.
  always_comb begin
    if (mode || last) begin
      pos_nxt = '0;
      sum_nxt = 16'd0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
      sum_nxt = sum_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= 16'd0;
    end else if (step) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Byte history; the newest byte sits at the low end.
  always_ff @(posedge clk) begin
    if (step && !mode) begin
      shift_r[0] <= rx_byte;
      for (int i = 1; i < FRAME_BYTES - 1; i++) begin
        shift_r[i] <= shift_r[i-1];
      end
    end
  end

  // Frame view at the last byte: the incoming byte closes the frame.
  for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_frame
    if (k == FRAME_BYTES - 1) begin : g_newest
      assign frame_byte[k] = rx_byte;
    end else begin : g_stored
      assign frame_byte[k] = shift_r[FRAME_BYTES-2-k];
    end
  end

  `PFP_ASSERT_NEXT(a_timeout_restarts, step && mode, pos_r == '0 && sum_r == 16'd0, "timeout did not restart frame")
  `PFP_ASSERT_NOW(a_pos_in_frame, 1'b1, pos_r <= POS_W'(FRAME_BYTES - 1), "byte position beyond frame")

endmodule

>>> rtl/pfp_result.sv
`include "particulate_frame_parser_assert.svh"

module pfp_result #(
  parameter int FRAME_BYTES  = 32,
  parameter int SUMMED_BYTES = 30
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic                 out_ready,
  input  logic [7:0]           frame_byte [FRAME_BYTES],
  input  pfp_pkg::pfp_status_t status,
  input  pfp_pkg::pfp_cfg_t    cfg,
  output logic                 out_valid,
  output pfp_pkg::pfp_result_t res
);
  import pfp_pkg::*;

  // Checksum bytes that fall outside the frame are never written; clamp the taps.
  localparam int CHK_HI = (SUMMED_BYTES < FRAME_BYTES) ? SUMMED_BYTES : FRAME_BYTES - 1;
  localparam int CHK_LO = (SUMMED_BYTES + 1 < FRAME_BYTES) ? SUMMED_BYTES + 1 : FRAME_BYTES - 1;

  logic        out_valid_r;
  pfp_result_t res_r;
  pfp_result_t res_nxt;
  logic        frame_ok;
  logic [15:0] pm_word    [NUM_PM];
  logic [15:0] count_word [NUM_COUNTS];

  // Header and checksum check.
  assign frame_ok = (frame_byte[0] == cfg.header_first) &&
                    (frame_byte[1] == cfg.header_second) &&
                    (status.sum == {frame_byte[CHK_HI], frame_byte[CHK_LO]});

  // Word selection; the context picks the standard or atmospheric set.
  always_comb begin
    for (int i = 0; i < NUM_PM; i++) begin
      if (cfg.context_atm) begin
        pm_word[i] = {frame_byte[ATM_BASE + 2*i], frame_byte[ATM_BASE + 2*i + 1]};
      end else begin
        pm_word[i] = {frame_byte[STD_BASE + 2*i], frame_byte[STD_BASE + 2*i + 1]};
      end
    end
    for (int j = 0; j < NUM_COUNTS; j++) begin
      count_word[j] = {frame_byte[COUNT_BASE + 2*j], frame_byte[COUNT_BASE + 2*j + 1]};
    end
  end

  // A failed frame gives an all-zero result.
  always_comb begin
    res_nxt = '0;
    if (frame_ok) begin
      res_nxt.frame_ok  = 1'b1;
      res_nxt.pm1_0     = pm_word[0];
      res_nxt.pm2_5     = pm_word[1];
      res_nxt.pm10      = pm_word[2];
      res_nxt.count_0_3 = count_word[0];
      res_nxt.count_0_5 = count_word[1];
      res_nxt.count_1_0 = count_word[2];
      res_nxt.count_2_5 = count_word[3];
      res_nxt.count_5_0 = count_word[4];
      res_nxt.count_10  = count_word[5];
    end
  end

  // Output register; it holds until the transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  `PFP_ASSERT_NEXT(a_load_shows_result, load, out_valid_r, "loaded result not presented")
  `PFP_ASSERT_NOW(a_fail_is_zero, out_valid_r && !res_r.frame_ok, res_r.pm1_0 == 16'd0 && res_r.pm10 == 16'd0 && res_r.count_0_3 == 16'd0 && res_r.count_10 == 16'd0, "failed frame carries nonzero data")

endmodule

>>> rtl/particulate_frame_parser.sv
// Particulate sensor frame parser.
// The last byte of a frame is held in the input register; its result is then registered in the
// output register and raises out_valid. Throughput: one byte per cycle; the input register
// stalls only when a frame-closing byte finds the output register still holding an untaken result.
// Reset (synchronous, active low) clears the byte position, running sum, pipeline valids
// and restores the header and context registers to their defaults.
`include "particulate_frame_parser_assert.svh"

module particulate_frame_parser #(
  parameter int FRAME_BYTES  = 32,
  parameter int SUMMED_BYTES = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  // Byte stream
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_rx_byte,
  // Results
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_ok,
  output logic [15:0] out_pm1_0,
  output logic [15:0] out_pm2_5,
  output logic [15:0] out_pm10,
  output logic [15:0] out_count_0_3,
  output logic [15:0] out_count_0_5,
  output logic [15:0] out_count_1_0,
  output logic [15:0] out_count_2_5,
  output logic [15:0] out_count_5_0,
  output logic [15:0] out_count_10,
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import pfp_pkg::*;

  logic        s1_valid_r;
  logic        s1_mode_r;
  logic [7:0]  s1_byte_r;
  logic        s1_go;
  logic        load;
  logic        out_busy;
  logic        res_valid;
  logic [7:0]  header_first_r;
  logic [7:0]  header_second_r;
  logic        context_r;
  logic [7:0]  frame_byte [FRAME_BYTES];
  pfp_status_t status;
  pfp_cfg_t    cfg;
  pfp_result_t res;

  // Configuration registers; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r  <= HEADER_FIRST_RST;
      header_second_r <= HEADER_SECOND_RST;
      context_r       <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEADER_FIRST:  header_first_r  <= cfg_data;
        REG_HEADER_SECOND: header_second_r <= cfg_data;
        REG_CONTEXT:       context_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.header_first  = header_first_r;
  assign cfg.header_second = header_second_r;
  assign cfg.context_atm   = context_r;

  // Input stage moves on unless a frame result meets a full output register.
  assign out_busy = res_valid && !out_ready;
  assign s1_go    = s1_valid_r && (!status.last || !out_busy);
  assign load     = s1_go && status.last;
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r <= in_mode;
      s1_byte_r <= in_rx_byte;
    end
  end

  pfp_assembler #(
    .FRAME_BYTES  (FRAME_BYTES),
    .SUMMED_BYTES (SUMMED_BYTES)
  ) u_assembler (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_go),
    .mode       (s1_mode_r),
    .rx_byte    (s1_byte_r),
    .frame_byte (frame_byte),
    .status     (status)
  );

  pfp_result #(
    .FRAME_BYTES  (FRAME_BYTES),
    .SUMMED_BYTES (SUMMED_BYTES)
  ) u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .status     (status),
    .cfg        (cfg),
    .out_valid  (res_valid),
    .res        (res)
  );

  // Result ports.
  assign out_valid     = res_valid;
  assign out_frame_ok  = res.frame_ok;
  assign out_pm1_0     = res.pm1_0;
  assign out_pm2_5     = res.pm2_5;
  assign out_pm10      = res.pm10;
  assign out_count_0_3 = res.count_0_3;
  assign out_count_0_5 = res.count_0_5;
  assign out_count_1_0 = res.count_1_0;
  assign out_count_2_5 = res.count_2_5;
  assign out_count_5_0 = res.count_5_0;
  assign out_count_10  = res.count_10;

  `PFP_ASSERT_NOW(a_stall_needs_blocked_frame, !in_ready, s1_valid_r && status.last && out_busy, "input stalled without a blocked frame result")

endmodule
